/* rtl/vector3_arith_unit_core_assert.svh */
// assertion macros for the vector arithmetic unit
// expects clk and arst_n in the scope of use
`ifndef VECTOR3_ARITH_UNIT_CORE_ASSERT_SVH
`define VECTOR3_ARITH_UNIT_CORE_ASSERT_SVH

// same-cycle implication
`define V3AU_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define V3AU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/v3au_pkg.sv */
// shared types, constants and saturation helper for the vector arithmetic unit
// no dependencies
package v3au_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int SQRT_STAGES = 32;
	localparam int DIV_STAGES  = FRAC_BITS + 1;

	typedef enum logic [2:0] {
		FN_SCALE = 3'd0,
		FN_DOT   = 3'd1,
		FN_CROSS = 3'd2,
		FN_MAG   = 3'd3,
		FN_NORM  = 3'd4
	} func_t;

	typedef struct packed {
		logic signed [31:0] val;
		logic               clip;
	} lane_res_t;

	function automatic lane_res_t sat_w(input logic signed [65:0] v);
		lane_res_t r;
		r.clip = !((&v[65:31]) || !(|v[65:31]));
		if (r.clip) begin
			r.val = v[65] ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else begin
			r.val = v[31:0];
		end
		return r;
	endfunction

endpackage

/* rtl/v3au_lane.sv */
// one component lane: two multipliers, difference, floor shift and saturation
// depends on v3au_pkg
module v3au_lane import v3au_pkg::*; (
	input  logic               clk,
	input  logic [2:0]         func,
	input  logic signed [31:0] ai,
	input  logic signed [31:0] bi,
	input  logic signed [31:0] aj,
	input  logic signed [31:0] bj,
	input  logic signed [31:0] ak,
	input  logic signed [31:0] bk,
	input  logic signed [31:0] sc,
	output logic signed [63:0] p0_s1,
	output lane_res_t          res_s2
);

	logic signed [31:0] m0a, m0b, m1a, m1b;
	logic signed [63:0] p1_s1;
	logic signed [65:0] diff;

	always_comb begin
		m0a = '0;
		m0b = '0;
		m1a = '0;
		m1b = '0;
		case (func)
			FN_SCALE: begin
				m0a = ai;
				m0b = sc;
			end
			FN_DOT: begin
				m0a = ai;
				m0b = bi;
			end
			FN_CROSS: begin
				m0a = aj;
				m0b = bk;
				m1a = ak;
				m1b = bj;
			end
			FN_MAG, FN_NORM: begin
				m0a = ai;
				m0b = ai;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		p0_s1 <= m0a * m0b;
		p1_s1 <= m1a * m1b;
	end

	assign diff = 66'(p0_s1) - 66'(p1_s1);

	always_ff @(posedge clk) begin
		res_s2 <= sat_w(diff >>> FRAC_BITS);
	end

endmodule

/* rtl/v3au_sqrt.sv */
// pipelined integer square root, one root bit per stage
// depends on v3au_pkg
module v3au_sqrt import v3au_pkg::*; (
	input  logic        clk,
	input  logic [63:0] rad,
	output logic [31:0] root
);

	localparam int RW = 34;

	logic [RW-1:0] rem_s  [SQRT_STAGES];
	logic [31:0]   root_s [SQRT_STAGES];
	logic [63:0]   rad_s  [SQRT_STAGES];

	for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
		logic [RW-1:0] rem_p;
		logic [31:0]   root_p;
		logic [63:0]   rad_p;
		logic [RW+1:0] rem_x, trial;

		if (k == 0) begin : g_first
			assign rem_p  = '0;
			assign root_p = '0;
			assign rad_p  = rad;
		end else begin : g_next
			assign rem_p  = rem_s[k-1];
			assign root_p = root_s[k-1];
			assign rad_p  = rad_s[k-1];
		end

		assign rem_x = {rem_p, rad_p[63:62]};
		assign trial = (RW+2)'({root_p, 2'b01});

		always_ff @(posedge clk) begin
			if (rem_x >= trial) begin
				rem_s[k]  <= RW'(rem_x - trial);
				root_s[k] <= {root_p[30:0], 1'b1};
			end else begin
				rem_s[k]  <= RW'(rem_x);
				root_s[k] <= {root_p[30:0], 1'b0};
			end
			rad_s[k] <= {rad_p[61:0], 2'b00};
		end
	end

	assign root = root_s[SQRT_STAGES-1];

endmodule

/* rtl/v3au_div.sv */
// pipelined restoring divider for (mag << FRAC_BITS) / m, one quotient bit per stage
// depends on v3au_pkg; requires mag <= m
module v3au_div import v3au_pkg::*; (
	input  logic                  clk,
	input  logic [31:0]           mag,
	input  logic [31:0]           m,
	output logic [DIV_STAGES-1:0] quo
);

	localparam int DW = 33;

	logic [DW-1:0]         rem_s [DIV_STAGES];
	logic [31:0]           m_s   [DIV_STAGES];
	logic [DIV_STAGES-1:0] q_s   [DIV_STAGES];

	for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
		logic [DW-1:0]         rem_p;
		logic [31:0]           m_p;
		logic [DIV_STAGES-1:0] q_p;
		logic                  bit_p;
		logic [DW:0]           rin, dvs;
		logic                  ge;

		if (j == 0) begin : g_first
			assign rem_p = DW'(mag[31:1]);
			assign bit_p = mag[0];
			assign m_p   = m;
			assign q_p   = '0;
		end else begin : g_next
			assign rem_p = rem_s[j-1];
			assign bit_p = 1'b0;
			assign m_p   = m_s[j-1];
			assign q_p   = q_s[j-1];
		end

		assign rin = {rem_p, bit_p};
		assign dvs = (DW+1)'(m_p);
		assign ge  = rin >= dvs;

		always_ff @(posedge clk) begin
			rem_s[j] <= ge ? DW'(rin - dvs) : DW'(rin);
			m_s[j]   <= m_p;
			q_s[j]   <= {q_p[DIV_STAGES-2:0], ge};
		end
	end

	assign quo = q_s[DIV_STAGES-1];

endmodule

/* rtl/vector3_arith_unit_core.sv */
// top level of the three-component vector arithmetic unit: lanes, merge, root, dividers
// depends on v3au_pkg, v3au_lane, v3au_sqrt, v3au_div, vector3_arith_unit_core_assert.svh
//
//  channel   handshake        payload
//  command   start / busy     func ax ay az bx by_comp bz scale_factor
//  result    done (strobe)    res_x res_y res_z res_scalar saturated zero_length
//
// one transaction accepted every cycle, busy stays low
// a transaction passes the lanes, the merge, the square root and the normalize dividers in order,
// with one root bit per square root stage and one quotient bit per divider stage
// results come out in order, one strobe cycle each; the receiver cannot stall
// asynchronous active-low reset clears the valid chain only
module vector3_arith_unit_core import v3au_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [2:0]         func,
	input  logic signed [31:0] ax,
	input  logic signed [31:0] ay,
	input  logic signed [31:0] az,
	input  logic signed [31:0] bx,
	input  logic signed [31:0] by_comp,
	input  logic signed [31:0] bz,
	input  logic signed [31:0] scale_factor,
	output logic               done,
	output logic signed [31:0] res_x,
	output logic signed [31:0] res_y,
	output logic signed [31:0] res_z,
	output logic signed [31:0] res_scalar,
	output logic               saturated,
	output logic               zero_length
);

	`include "vector3_arith_unit_core_assert.svh"

	typedef struct packed {
		logic [2:0]         func;
		logic signed [31:0] rx;
		logic signed [31:0] ry;
		logic signed [31:0] rz;
		logic signed [31:0] rs;
		logic               clip;
		logic               zero;
		logic [2:0]         neg;
		logic [2:0][31:0]   mag;
	} meta_t;

	function automatic logic [31:0] abs32(input logic signed [31:0] v);
		return v[31] ? 32'(32'd0 - $unsigned(v)) : $unsigned(v);
	endfunction

	function automatic logic signed [31:0] apply_sign(input logic neg,
		input logic [DIV_STAGES-1:0] q);
		logic [31:0] qv;
		qv = 32'(q);
		return neg ? $signed(32'(32'd0 - qv)) : $signed(qv);
	endfunction

	logic                vld_s1, vld_s2;
	logic [2:0]          func_s1;
	logic signed [31:0]  ax_s1, ay_s1, az_s1;
	logic signed [63:0]  p0x, p0y, p0z;
	lane_res_t           lx, ly, lz;
	lane_res_t           dot_s2;
	logic [63:0]         sq_s2;
	meta_t               meta_s2, meta_mrg, meta_mid, meta_o;
	meta_t               meta_sq [SQRT_STAGES];
	meta_t               meta_dv [DIV_STAGES];
	logic                vld_sq [SQRT_STAGES];
	logic                vld_dv [DIV_STAGES];
	logic [31:0]         root;
	logic [DIV_STAGES-1:0] qx, qy, qz;
	logic signed [65:0]  dot_sum;

	assign busy = 1'b0;

	v3au_lane u_lane_x (
		.clk(clk), .func(func), .ai(ax), .bi(bx), .aj(ay), .bj(by_comp),
		.ak(az), .bk(bz), .sc(scale_factor), .p0_s1(p0x), .res_s2(lx)
	);
	v3au_lane u_lane_y (
		.clk(clk), .func(func), .ai(ay), .bi(by_comp), .aj(az), .bj(bz),
		.ak(ax), .bk(bx), .sc(scale_factor), .p0_s1(p0y), .res_s2(ly)
	);
	v3au_lane u_lane_z (
		.clk(clk), .func(func), .ai(az), .bi(bz), .aj(ax), .bj(bx),
		.ak(ay), .bk(by_comp), .sc(scale_factor), .p0_s1(p0z), .res_s2(lz)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			for (int k = 0; k < SQRT_STAGES; k++) vld_sq[k] <= 1'b0;
			for (int j = 0; j < DIV_STAGES; j++) vld_dv[j] <= 1'b0;
			done <= 1'b0;
		end else begin
			vld_s1    <= start && !busy;
			vld_s2    <= vld_s1;
			vld_sq[0] <= vld_s2;
			for (int k = 1; k < SQRT_STAGES; k++) vld_sq[k] <= vld_sq[k-1];
			vld_dv[0] <= vld_sq[SQRT_STAGES-1];
			for (int j = 1; j < DIV_STAGES; j++) vld_dv[j] <= vld_dv[j-1];
			done <= vld_dv[DIV_STAGES-1];
		end
	end

	always_ff @(posedge clk) begin
		func_s1 <= func;
		ax_s1   <= ax;
		ay_s1   <= ay;
		az_s1   <= az;
	end

	assign dot_sum = 66'(p0x) + 66'(p0y) + 66'(p0z);

	always_comb begin
		meta_s2 = '0;
		meta_s2.func = func_s1;
		meta_s2.neg  = {az_s1[31], ay_s1[31], ax_s1[31]};
		meta_s2.mag  = {abs32(az_s1), abs32(ay_s1), abs32(ax_s1)};
	end

	meta_t meta_r_s2;

	always_ff @(posedge clk) begin
		meta_r_s2 <= meta_s2;
		dot_s2    <= sat_w(dot_sum >>> FRAC_BITS);
		sq_s2     <= $unsigned(p0x) + $unsigned(p0y) + $unsigned(p0z);
	end

	// lane and dot merge
	always_comb begin
		meta_mrg = meta_r_s2;
		case (meta_r_s2.func)
			FN_SCALE, FN_CROSS: begin
				meta_mrg.rx   = lx.val;
				meta_mrg.ry   = ly.val;
				meta_mrg.rz   = lz.val;
				meta_mrg.clip = lx.clip | ly.clip | lz.clip;
			end
			FN_DOT: begin
				meta_mrg.rs   = dot_s2.val;
				meta_mrg.clip = dot_s2.clip;
			end
			default: begin
			end
		endcase
	end

	v3au_sqrt u_sqrt (.clk(clk), .rad(sq_s2), .root(root));

	always_ff @(posedge clk) begin
		meta_sq[0] <= meta_mrg;
		for (int k = 1; k < SQRT_STAGES; k++) meta_sq[k] <= meta_sq[k-1];
	end

	always_comb begin
		meta_mid = meta_sq[SQRT_STAGES-1];
		case (meta_mid.func)
			FN_MAG: begin
				meta_mid.rs   = root[31] ? 32'sh7fff_ffff : $signed(root);
				meta_mid.clip = root[31];
			end
			FN_NORM: begin
				if (root == '0) begin
					meta_mid.zero = 1'b1;
				end else begin
					meta_mid.rs   = root[31] ? 32'sh7fff_ffff : $signed(root);
					meta_mid.clip = root[31];
				end
			end
			default: begin
			end
		endcase
	end

	v3au_div u_div_x (.clk(clk), .mag(meta_sq[SQRT_STAGES-1].mag[0]), .m(root), .quo(qx));
	v3au_div u_div_y (.clk(clk), .mag(meta_sq[SQRT_STAGES-1].mag[1]), .m(root), .quo(qy));
	v3au_div u_div_z (.clk(clk), .mag(meta_sq[SQRT_STAGES-1].mag[2]), .m(root), .quo(qz));

	always_ff @(posedge clk) begin
		meta_dv[0] <= meta_mid;
		for (int j = 1; j < DIV_STAGES; j++) meta_dv[j] <= meta_dv[j-1];
	end

	always_comb begin
		meta_o = meta_dv[DIV_STAGES-1];
		if (meta_o.func == FN_NORM && !meta_o.zero) begin
			meta_o.rx = apply_sign(meta_o.neg[0], qx);
			meta_o.ry = apply_sign(meta_o.neg[1], qy);
			meta_o.rz = apply_sign(meta_o.neg[2], qz);
		end
	end

	always_ff @(posedge clk) begin
		res_x       <= meta_o.rx;
		res_y       <= meta_o.ry;
		res_z       <= meta_o.rz;
		res_scalar  <= meta_o.rs;
		saturated   <= meta_o.clip;
		zero_length <= meta_o.zero;
	end

	`V3AU_ASSERT_NEXT(a_start_enters, start && !busy, vld_s1,
		"accepted transaction did not enter the pipeline")
	`V3AU_ASSERT_IMPL(a_sqrt_aligned, vld_sq[SQRT_STAGES-1], $past(vld_s2, SQRT_STAGES),
		"root stage valid without matching merge stage")
	`V3AU_ASSERT_NEXT(a_out_follows, vld_dv[DIV_STAGES-1], done,
		"divider output not strobed")
	`V3AU_ASSERT_IMPL(a_zero_clean, done && zero_length,
		res_x == 0 && res_y == 0 && res_z == 0 && res_scalar == 0 && !saturated,
		"zero length result not cleared")

endmodule
